>>> sv/lzcd_pkg.sv
package lzcd_pkg;

  // History window; the store holds the last WindowBytes output bytes of a frame.
  localparam int unsigned WindowBytes = 65536;
  localparam int unsigned HistAw      = $clog2(WindowBytes);
  localparam int unsigned CountW      = 35;
  localparam int unsigned LitW        = 33;
  localparam int unsigned OffW        = 32;
  localparam int unsigned CopyLenW    = 7;

  typedef logic [HistAw-1:0] hist_addr_t;
  typedef logic [2:0]        status_t;

  localparam status_t StOk       = 3'd0;
  localparam status_t StPreamble = 3'd1;
  localparam status_t StTrunc    = 3'd2;
  localparam status_t StOffset   = 3'd3;
  localparam status_t StLength   = 3'd4;

  // element kind, low two bits of a tag byte
  localparam logic [1:0] TagLiteral = 2'd0;
  localparam logic [1:0] TagCopy1   = 2'd1;
  localparam logic [1:0] TagCopy2   = 2'd2;
  localparam logic [1:0] TagCopy4   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    status_t    status;
  } out_item_t;

  typedef struct packed {
    logic       we;
    hist_addr_t addr;
    logic [7:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic       re;
    hist_addr_t addr;
  } hist_rd_t;

  typedef struct packed {
    logic                start;
    hist_addr_t          src;
    logic [CopyLenW-1:0] len;
  } copy_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       pend;
    logic       last_byte;
    logic [7:0] data;
  } copy_sts_t;

  function automatic hist_addr_t hist_next(hist_addr_t a);
    hist_addr_t r;
    if (a == HistAw'(WindowBytes - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

endpackage

>>> sv/lzcd_hist_ram.sv
module lzcd_hist_ram (
  input  logic               clk_i,
  input  lzcd_pkg::hist_wr_t wr_i,
  input  lzcd_pkg::hist_rd_t rd_i,
  output logic [7:0]         rdata_o
);
  import lzcd_pkg::*;

  logic [7:0] mem_q [WindowBytes];
  logic [7:0] rdata_q;

  // Read-first: a same-cycle write to the read address is forwarded by the caller.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lzcd_copy_engine.sv
module lzcd_copy_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzcd_pkg::copy_cmd_t cmd_i,
  input  logic                take_i,
  input  logic                hold_i,
  input  lzcd_pkg::hist_wr_t  wr_i,
  input  logic [7:0]          rdata_i,
  output lzcd_pkg::hist_rd_t  rd_o,
  output lzcd_pkg::copy_sts_t sts_o
);
  import lzcd_pkg::*;

  hist_addr_t          src_q, src_d;
  logic [CopyLenW-1:0] left_q, left_d;
  logic                pend_q, pend_d;
  logic                fwd_q, fwd_d;
  logic [7:0]          fwd_data_q, fwd_data_d;
  logic                issue;

  // One read in flight; the next read goes out in the cycle the pending byte is taken.
  assign issue = (left_q != '0) && (!pend_q || take_i);

  always_comb begin
    src_d      = src_q;
    left_d     = left_q;
    pend_d     = pend_q;
    fwd_d      = fwd_q;
    fwd_data_d = fwd_data_q;
    if (cmd_i.start) begin
      src_d  = cmd_i.src;
      left_d = cmd_i.len;
    end else if (issue) begin
      // source stops moving once the byte count has saturated
      src_d  = hold_i ? src_q : hist_next(src_q);
      left_d = left_q - 1'b1;
    end
    if (issue) begin
      pend_d     = 1'b1;
      // offset 1: the source byte is being written this very cycle
      fwd_d      = wr_i.we && (wr_i.addr == src_q);
      fwd_data_d = wr_i.data;
    end else if (take_i) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      pend_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      left_q <= left_d;
      pend_q <= pend_d;
      fwd_q  <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    fwd_data_q <= fwd_data_d;
  end

  assign rd_o.re   = issue;
  assign rd_o.addr = src_q;

  assign sts_o.busy      = pend_q || (left_q != '0);
  assign sts_o.pend      = pend_q;
  assign sts_o.last_byte = (left_q == '0);
  assign sts_o.data      = fwd_q ? fwd_data_q : rdata_i;

endmodule

>>> sv/lz_copy_literal_decompressor_unit.sv
// Raw LZ77-style decompressor with literal and copy tags, one compressed byte
// per input transaction. Preamble, tag, extra-length, offset and literal bytes
// are taken one per clock as long as the output register drains; a literal
// byte leaves as one result. After the last offset byte of a copy the block
// checks the offset, starts the copy engine and waits for the first history
// read, then emits the copy at one byte per clock while the output register
// drains (input held meanwhile); the history memory has a single read port
// and a registered read. An offset of one is served by forwarding the
// byte being written. Results that carry no byte (errors, empty body) have
// out_valid = 0 and done_res = 1. After an error the rest of the frame is
// dropped until the byte marked in_last. The history memory needs no clearing.
module lz_copy_literal_decompressor_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lzcd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lzcd_pkg::out_item_t out_data_o
);
  import lzcd_pkg::*;

  typedef enum logic [2:0] {
    SPre, STag, SLitX, SLitD, SCoff, SCheck, SCopy, SDrain
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   exp_q, exp_d;
  logic [CountW-1:0]   oc_q, oc_d;
  logic [2:0]          pc_q, pc_d;
  logic [LitW-1:0]     litrem_q, litrem_d;
  logic [2:0]          xleft_q, xleft_d;
  logic [CopyLenW-1:0] clen_q, clen_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [1:0]          ckind_q, ckind_d;
  logic                last_q, last_d;
  hist_addr_t          wptr_q, wptr_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic       can_load, acc, take, copy_hold;
  hist_wr_t   wr;
  hist_rd_t   rd;
  copy_cmd_t  cmd;
  copy_sts_t  sts;
  logic [7:0] rdata;

  lzcd_hist_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  lzcd_copy_engine u_copy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .take_i  (take),
    .hold_i  (copy_hold),
    .wr_i    (wr),
    .rdata_i (rdata),
    .rd_o    (rd),
    .sts_o   (sts)
  );

  assign can_load  = !out_valid_q || out_ready_i;
  assign take      = (state_q == SCopy) && sts.pend && can_load;
  assign acc       = in_valid_i && in_ready_o;
  assign copy_hold = (oc_d == '1);

  always_comb begin
    unique case (state_q) inside
      SPre, STag, SLitX, SLitD, SCoff: in_ready_o = can_load;
      SDrain:                          in_ready_o = 1'b1;
      default:                         in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    logic [7:0]        b;
    logic              last;
    logic [1:0]        kind;
    logic [5:0]        hi;
    logic [5:0]        sh;
    logic [CountW-1:0] exp_nx;
    logic [CountW-1:0] oc_inc;
    hist_addr_t        wptr_inc;
    logic [1:0]        idx;
    logic [2:0]        total;
    logic [LitW-1:0]   lit_or;
    logic [OffW-1:0]   off_or;
    logic              bad_off;
    logic [HistAw:0]   wext, offw, diff;
    logic              ld;
    out_item_t         item;
    logic              clr;

    b    = in_data_i.in_byte;
    last = in_data_i.in_last;
    kind = b[1:0];
    hi   = b[7:2];
    sh   = {pc_q, 3'b000} - {3'b000, pc_q};
    exp_nx = exp_q | ({{(CountW-7){1'b0}}, b[6:0]} << sh);
    oc_inc   = (oc_q == '1) ? oc_q : oc_q + 1'b1;
    wptr_inc = (oc_q == '1) ? wptr_q : hist_next(wptr_q);
    idx   = 2'(3'({1'b0, ckind_q}) + 3'd1 - xleft_q);
    total = (ckind_q == TagCopy4) ? 3'd4 : {1'b0, ckind_q};
    lit_or = litrem_q | (LitW'(b) << {idx, 3'b000});
    off_or = off_q | (OffW'(b) << {2'(total - xleft_q), 3'b000});
    bad_off = (off_q == '0) || (CountW'(off_q) > oc_q) ||
              ((OffW + 1)'(off_q) > (OffW + 1)'(WindowBytes));
    wext = {1'b0, wptr_q};
    offw = off_q[HistAw:0];
    diff = wext - offw;
    if (wext < offw) begin
      diff = diff + (HistAw + 1)'(WindowBytes);
    end

    state_d  = state_q;
    exp_d    = exp_q;
    oc_d     = oc_q;
    pc_d     = pc_q;
    litrem_d = litrem_q;
    xleft_d  = xleft_q;
    clen_d   = clen_q;
    off_d    = off_q;
    ckind_d  = ckind_q;
    last_d   = last_q;
    wptr_d   = wptr_q;
    wr       = '0;
    cmd      = '0;
    ld       = 1'b0;
    item     = '{out_byte: 8'd0, out_valid: 1'b0, done_res: 1'b1, status: StOk};
    clr      = 1'b0;

    unique case (state_q)
      SPre: begin
        if (acc) begin
          exp_d = exp_nx;
          if (!b[7]) begin
            state_d = STag;
            if (last) begin
              ld          = 1'b1;
              item.status = (exp_nx == oc_q) ? StOk : StLength;
              clr         = 1'b1;
            end
          end else if (pc_q >= 3'd4 || last) begin
            ld          = 1'b1;
            item.status = StPreamble;
            if (last) begin
              clr = 1'b1;
            end else begin
              state_d = SDrain;
            end
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      STag: begin
        if (acc) begin
          off_d = '0;
          if (kind == TagLiteral) begin
            if (hi >= 6'd60) begin
              xleft_d  = 3'(hi - 6'd59);
              ckind_d  = 2'(hi - 6'd60);
              litrem_d = '0;
              state_d  = SLitX;
            end else begin
              litrem_d = LitW'(hi) + 1'b1;
              state_d  = SLitD;
            end
          end else begin
            ckind_d = kind;
            if (kind == TagCopy1) begin
              clen_d  = 7'd4 + CopyLenW'(hi[2:0]);
              off_d   = {{(OffW-11){1'b0}}, b[7:5], 8'd0};
              xleft_d = 3'd1;
            end else begin
              clen_d  = CopyLenW'(hi) + 1'b1;
              xleft_d = (kind == TagCopy2) ? 3'd2 : 3'd4;
            end
            state_d = SCoff;
          end
          if (last) begin
            ld          = 1'b1;
            item.status = StTrunc;
            clr         = 1'b1;
          end
        end
      end
      SLitX: begin
        if (acc) begin
          xleft_d = xleft_q - 1'b1;
          if (xleft_q == 3'd1) begin
            litrem_d = lit_or + 1'b1;
            state_d  = SLitD;
          end else begin
            litrem_d = lit_or;
          end
          if (last) begin
            ld          = 1'b1;
            item.status = StTrunc;
            clr         = 1'b1;
          end
        end
      end
      SLitD: begin
        if (acc) begin
          wr       = '{we: 1'b1, addr: wptr_q, data: b};
          oc_d     = oc_inc;
          wptr_d   = wptr_inc;
          litrem_d = litrem_q - 1'b1;
          ld       = 1'b1;
          item     = '{out_byte: b, out_valid: 1'b1, done_res: 1'b0, status: StOk};
          if (litrem_q == LitW'(1)) begin
            state_d = STag;
          end
          if (last) begin
            item.done_res = 1'b1;
            if (litrem_q != LitW'(1)) begin
              item.status = StTrunc;
            end else begin
              item.status = (oc_inc == exp_q) ? StOk : StLength;
            end
            clr = 1'b1;
          end
        end
      end
      SCoff: begin
        if (acc) begin
          off_d   = off_or;
          xleft_d = xleft_q - 1'b1;
          if (xleft_q != 3'd1) begin
            if (last) begin
              ld          = 1'b1;
              item.status = StTrunc;
              clr         = 1'b1;
            end
          end else begin
            state_d = SCheck;
            last_d  = last;
          end
        end
      end
      SCheck: begin
        if (bad_off) begin
          if (can_load) begin
            ld          = 1'b1;
            item.status = StOffset;
            if (last_q) begin
              clr = 1'b1;
            end else begin
              state_d = SDrain;
            end
          end
        end else begin
          cmd     = '{start: 1'b1, src: diff[HistAw-1:0], len: clen_q};
          state_d = SCopy;
        end
      end
      SCopy: begin
        if (take) begin
          wr     = '{we: 1'b1, addr: wptr_q, data: sts.data};
          oc_d   = oc_inc;
          wptr_d = wptr_inc;
          ld     = 1'b1;
          item   = '{out_byte: sts.data, out_valid: 1'b1, done_res: 1'b0, status: StOk};
          if (sts.last_byte) begin
            if (last_q) begin
              item.done_res = 1'b1;
              item.status   = (oc_inc == exp_q) ? StOk : StLength;
              clr           = 1'b1;
            end else begin
              state_d = STag;
            end
          end
        end
      end
      SDrain: begin
        if (acc && last) begin
          clr = 1'b1;
        end
      end
      default: begin
        state_d = SPre;
      end
    endcase

    if (clr) begin
      state_d = SPre;
      exp_d   = '0;
      oc_d    = '0;
      pc_d    = '0;
      wptr_d  = '0;
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (ld) begin
      out_valid_d = 1'b1;
      out_data_d  = item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SPre;
      exp_q       <= '0;
      oc_q        <= '0;
      pc_q        <= '0;
      wptr_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      oc_q        <= oc_d;
      pc_q        <= pc_d;
      wptr_q      <= wptr_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    litrem_q   <= litrem_d;
    xleft_q    <= xleft_d;
    clen_q     <= clen_d;
    off_q      <= off_d;
    ckind_q    <= ckind_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/lzcd_checker.sv
module lzcd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input lzcd_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lzcd_pkg::out_item_t out_data_o
);
  import lzcd_pkg::*;

  // An offered input transaction holds until taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // A result without a byte is always a frame end or an error, with a zero byte.
  a_empty_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |-> out_data_o.done_res &&
    (out_data_o.out_byte == 8'd0))
    else $error("byte-less result is not a frame end");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == StOk)
    else $error("status set on a non-final result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= StLength)
    else $error("status code out of range");

endmodule

bind lz_copy_literal_decompressor_unit lzcd_checker u_lzcd_checker (.*);
